// ===== hdl/crpe_pkg.sv =====
// ----------------------------------------------------------------------------
// crpe_pkg : shared constants and types for the Catmull-Rom point evaluator
// Fixed-point widths, word layout and sequencer states.
// ----------------------------------------------------------------------------
package crpe_pkg;

    // curve parameter format: unsigned Q1.T_FRAC_BITS, 1.0 included
    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;

    // coordinates and multiplier operands
    localparam int COORD_W = 32;
    localparam int MUL_A_W = COORD_W + 1;
    localparam int W_W     = T_FRAC_BITS + 4;
    localparam int PROD_W  = MUL_A_W + W_W;
    localparam int ACC_W   = PROD_W + 3;

    // window geometry and multiply-accumulate schedule
    localparam int AXES     = 3;
    localparam int TAPS     = 4;
    localparam int AXIS_W   = $clog2(AXES);
    localparam int TAP_W    = $clog2(TAPS);
    localparam int MAC_LAST = AXES * TAPS;
    localparam int CNT_W    = $clog2(MAC_LAST + 1);

    // stream word layout
    localparam int S_TDATA_W = ((3 * COORD_W + T_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 3 * COORD_W;
    localparam int T_LSB     = 3 * COORD_W;

    // item kinds carried in s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_WEIGHT,
        ST_MAC,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/catmull_rom_point_eval_top.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_point_eval_top : uniform Catmull-Rom cubic segment in 3D
// Push words shift a control point into a four-point window; evaluate words
// return the weighted sum of the window per axis, using one shared multiplier.
// ----------------------------------------------------------------------------
// Push word: accepted while idle, no result word.
// Evaluate word: the input is not ready again until the result word has been loaded
// into the output register, so evaluations do not overlap. The schedule is set
// by the shared 33x20 multiplier: t squared, t cubed, then twelve products.
// Reset (aresetn low, synchronous) clears the window to zeros and the sequencer.
// ----------------------------------------------------------------------------
module catmull_rom_point_eval_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pt_x [31:0], pt_y [63:32], pt_z [95:64], param_t [112:96], zero pad
    input  logic [crpe_pkg::S_TDATA_W-1:0]     s_tdata,
    // op
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [crpe_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int TF    = crpe_pkg::T_FRAC_BITS;
    localparam int TW    = crpe_pkg::T_W;
    localparam int CW    = crpe_pkg::COORD_W;
    localparam int AW    = crpe_pkg::MUL_A_W;
    localparam int WW    = crpe_pkg::W_W;
    localparam int PW    = crpe_pkg::PROD_W;
    localparam int ACW   = crpe_pkg::ACC_W;
    localparam int CNTW  = crpe_pkg::CNT_W;
    localparam int AXW   = crpe_pkg::AXIS_W;
    localparam int TPW   = crpe_pkg::TAP_W;
    localparam int SQ_W  = 2 * TF + 2;

    localparam logic [TW-1:0]   T_ONE      = {1'b1, {TF{1'b0}}};
    localparam logic [SQ_W-1:0] T_HALF     = SQ_W'(1) << (TF - 1);
    localparam logic signed [WW-1:0]  TWO_ONE    = WW'(1) << (TF + 1);
    localparam logic signed [ACW-1:0] ROUND_BIAS = ACW'(1) << TF;
    localparam logic [CNTW-1:0] CNT_LAST   = CNTW'(crpe_pkg::MAC_LAST);

    crpe_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0]  win_reg [crpe_pkg::AXES][crpe_pkg::TAPS];
    logic [TW-1:0]         t_reg;
    logic [TW-1:0]         t2_reg;
    logic signed [WW-1:0]  w_reg [crpe_pkg::TAPS];
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic signed [CW-1:0]  res_reg [crpe_pkg::AXES];
    logic                  m_tvalid_reg;
    logic [crpe_pkg::M_TDATA_W-1:0] m_data_reg;

    // sequencer controls
    logic in_ready;
    logic push_en;
    logic eval_en;
    logic t2_load;
    logic w_load;
    logic acc_en;
    logic out_load;

    logic              accept;
    logic [TW-1:0]     t_in;
    logic [TW-1:0]     t_clamped;
    logic [SQ_W-1:0]   round_sum;
    logic [TW-1:0]     t_round;
    logic [CNTW-1:0]   k_idx;
    logic [AXW-1:0]    iss_axis;
    logic [TPW-1:0]    iss_tap;
    logic [AXW-1:0]    k_axis;
    logic [TPW-1:0]    k_tap;
    logic signed [AW-1:0]  mul_a;
    logic signed [WW-1:0]  mul_b;
    logic signed [PW-1:0]  prod_next;
    logic signed [ACW-1:0] acc_next;
    logic signed [ACW-TF-2:0] scaled;
    logic [ACW-TF-CW-1:0]  scaled_hi;
    logic signed [CW-1:0]  sat_val;
    logic signed [WW-1:0]  st, st2, st3;
    logic signed [WW-1:0]  w_next [crpe_pkg::TAPS];

    assign accept    = s_tvalid && in_ready;
    assign t_in      = s_tdata[crpe_pkg::T_LSB +: TW];
    assign t_clamped = (t_in > T_ONE) ? T_ONE : t_in;

    // round half up and drop the fraction of the last square or cube
    assign round_sum = prod_reg[SQ_W-1:0] + T_HALF;
    assign t_round   = round_sum[TF +: TW];

    assign k_idx    = cnt_reg - CNTW'(1);
    assign iss_axis = cnt_reg[TPW +: AXW];
    assign iss_tap  = cnt_reg[TPW-1:0];
    assign k_axis   = k_idx[TPW +: AXW];
    assign k_tap    = k_idx[TPW-1:0];

    // ---------------------------------------------------------------- FSM
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crpe_pkg::ST_IDLE: begin
                if (s_tvalid && s_tuser == crpe_pkg::OP_EVAL) begin
                    state_next = crpe_pkg::ST_SQ;
                end
            end
            crpe_pkg::ST_SQ:     state_next = crpe_pkg::ST_CUBE;
            crpe_pkg::ST_CUBE:   state_next = crpe_pkg::ST_WEIGHT;
            crpe_pkg::ST_WEIGHT: state_next = crpe_pkg::ST_MAC;
            crpe_pkg::ST_MAC: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = crpe_pkg::ST_DONE;
                end
            end
            crpe_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = crpe_pkg::ST_IDLE;
                end
            end
            default: state_next = crpe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        t2_load  = 1'b0;
        w_load   = 1'b0;
        acc_en   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            crpe_pkg::ST_IDLE:   in_ready = 1'b1;
            crpe_pkg::ST_CUBE:   t2_load  = 1'b1;
            crpe_pkg::ST_WEIGHT: w_load   = 1'b1;
            crpe_pkg::ST_MAC:    acc_en   = (cnt_reg != '0);
            crpe_pkg::ST_DONE:   out_load = !m_tvalid_reg || m_tready;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign push_en = accept && s_tuser == crpe_pkg::OP_PUSH;
    assign eval_en = accept && s_tuser == crpe_pkg::OP_EVAL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crpe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < crpe_pkg::AXES; a++) begin
                for (int i = 0; i < crpe_pkg::TAPS; i++) begin
                    win_reg[a][i] <= '0;
                end
            end
        end else if (push_en) begin
            for (int a = 0; a < crpe_pkg::AXES; a++) begin
                for (int i = 0; i < crpe_pkg::TAPS - 1; i++) begin
                    win_reg[a][i] <= win_reg[a][i+1];
                end
                win_reg[a][crpe_pkg::TAPS-1] <= s_tdata[a*CW +: CW];
            end
        end
    end

    // ---------------------------------------------------------------- multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            crpe_pkg::ST_SQ: begin
                mul_a = AW'(t_reg);
                mul_b = WW'(t_reg);
            end
            crpe_pkg::ST_CUBE: begin
                mul_a = AW'(t_round);
                mul_b = WW'(t_reg);
            end
            crpe_pkg::ST_MAC: begin
                if (cnt_reg != CNT_LAST) begin
                    mul_a = AW'(win_reg[iss_axis][iss_tap]);
                    mul_b = w_reg[iss_tap];
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // ---------------------------------------------------------------- weights
    assign st  = WW'(t_reg);
    assign st2 = WW'(t2_reg);
    assign st3 = WW'(t_round);

    always_comb begin
        w_next[0] = -st3 + (st2 <<< 1) - st;
        w_next[1] = (st3 <<< 1) + st3 - (st2 <<< 2) - st2 + TWO_ONE;
        w_next[2] = -((st3 <<< 1) + st3) + (st2 <<< 2) + st;
        w_next[3] = st3 - st2;
    end

    // ---------------------------------------------------------------- accumulate
    // restart each axis with the rounding bias so the final shift rounds half up
    assign acc_next  = ((k_tap == '0) ? ROUND_BIAS : acc_reg) + ACW'(prod_reg);
    assign scaled    = acc_next[ACW-1:TF+1];
    assign scaled_hi = scaled[ACW-TF-2:CW-1];
    assign sat_val   = ((&scaled_hi) || !(|scaled_hi)) ? scaled[CW-1:0] :
                       (scaled[ACW-TF-2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (eval_en) begin
            t_reg <= t_clamped;
        end
        if (t2_load) begin
            t2_reg <= t_round;
        end
        if (w_load) begin
            for (int i = 0; i < crpe_pkg::TAPS; i++) begin
                w_reg[i] <= w_next[i];
            end
        end
        if (acc_en) begin
            acc_reg <= acc_next;
            if (k_tap == TPW'(crpe_pkg::TAPS - 1)) begin
                res_reg[k_axis] <= sat_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (w_load) begin
            cnt_reg <= '0;
        end else if (state_reg == crpe_pkg::ST_MAC) begin
            cnt_reg <= cnt_reg + CNTW'(1);
        end
    end

    // ---------------------------------------------------------------- output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int a = 0; a < crpe_pkg::AXES; a++) begin
                m_data_reg[a*CW +: CW] <= res_reg[a];
            end
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule
